/* src/b64pd_pkg.sv */
// Shared types, status codes and character lookup functions for the
// base64 decoder with percent unescaping. No dependencies.

package b64pd_pkg;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_CHAR   = 2'd1,
    ST_BAD_HEX    = 2'd2,
    ST_UNFINISHED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_phase_t;

  localparam logic [7:0] CHAR_PAD     = 8'h3d;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;

  typedef struct packed {
    logic [5:0] bit_buffer;
    logic [2:0] bit_count;
    esc_phase_t escape_phase;
    logic [3:0] high_nibble;
    logic       pad_seen;
    status_t    err_status;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '{
    bit_buffer:   6'd0,
    bit_count:    3'd0,
    escape_phase: ESC_NONE,
    high_nibble:  4'd0,
    pad_seen:     1'b0,
    err_status:   ST_OK
  };

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_text;
    status_t    status;
  } dec_result_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } digit_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } nibble_t;

  function automatic digit_t b64_digit(input logic [7:0] c);
    digit_t d;
    d = '{ok: 1'b1, value: 6'd0};
    if (c inside {[8'h41:8'h5a]}) begin
      d.value = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7a]}) begin
      d.value = 6'(c - 8'h47);
    end else if (c inside {[8'h30:8'h39]}) begin
      d.value = 6'(c + 8'h04);
    end else if (c == 8'h2b) begin
      d.value = 6'd62;
    end else if (c == 8'h2f) begin
      d.value = 6'd63;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

  function automatic nibble_t hex_value(input logic [7:0] c);
    nibble_t n;
    n = '{ok: 1'b1, value: 4'd0};
    if (c inside {[8'h30:8'h39]}) begin
      n.value = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      n.value = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      n.value = 4'(c - 8'h37);
    end else begin
      n.ok = 1'b0;
    end
    return n;
  endfunction

endpackage

/* src/b64pd_step.sv */
// Next-state and result logic for one input character: base64 digit packing
// followed by the percent-unescape stage. Depends on b64pd_pkg.

module b64pd_step (
  input  b64pd_pkg::dec_state_t  state_i,
  input  logic [7:0]             char_code,
  input  logic                   last_char,
  output b64pd_pkg::dec_state_t  state_o,
  output b64pd_pkg::dec_result_t result_o
);

  b64pd_pkg::digit_t   dig;
  b64pd_pkg::nibble_t  hex;
  b64pd_pkg::dec_state_t nxt;
  logic [7:0]          packed_byte;
  logic                have_byte;
  logic                valid;
  logic [7:0]          byte_out;

  always_comb begin
    dig         = b64pd_pkg::b64_digit(char_code);
    nxt         = state_i;
    packed_byte = 8'd0;
    have_byte   = 1'b0;
    valid       = 1'b0;
    byte_out    = 8'd0;

    if (state_i.err_status == b64pd_pkg::ST_OK && !state_i.pad_seen) begin
      if (char_code == b64pd_pkg::CHAR_PAD) begin
        nxt.pad_seen = 1'b1;
      end else if (!dig.ok) begin
        nxt.err_status = b64pd_pkg::ST_BAD_CHAR;
      end else begin
        case (state_i.bit_count)
          3'd2: begin
            packed_byte   = {state_i.bit_buffer[1:0], dig.value};
            have_byte     = 1'b1;
            nxt.bit_buffer = 6'd0;
            nxt.bit_count  = 3'd0;
          end
          3'd4: begin
            packed_byte   = {state_i.bit_buffer[3:0], dig.value[5:2]};
            have_byte     = 1'b1;
            nxt.bit_buffer = {4'd0, dig.value[1:0]};
            nxt.bit_count  = 3'd2;
          end
          3'd6: begin
            packed_byte   = {state_i.bit_buffer[5:0], dig.value[5:4]};
            have_byte     = 1'b1;
            nxt.bit_buffer = {2'd0, dig.value[3:0]};
            nxt.bit_count  = 3'd4;
          end
          default: begin
            nxt.bit_buffer = dig.value;
            nxt.bit_count  = 3'(state_i.bit_count + 3'd6);
          end
        endcase
      end
    end

    hex = b64pd_pkg::hex_value(packed_byte);

    if (have_byte) begin
      case (state_i.escape_phase)
        b64pd_pkg::ESC_NONE: begin
          if (packed_byte == b64pd_pkg::CHAR_PERCENT) begin
            nxt.escape_phase = b64pd_pkg::ESC_HIGH;
          end else begin
            byte_out = packed_byte;
            valid    = 1'b1;
          end
        end
        b64pd_pkg::ESC_HIGH: begin
          if (!hex.ok) begin
            nxt.err_status = b64pd_pkg::ST_BAD_HEX;
          end else begin
            nxt.high_nibble  = hex.value;
            nxt.escape_phase = b64pd_pkg::ESC_LOW;
          end
        end
        default: begin
          if (!hex.ok) begin
            nxt.err_status = b64pd_pkg::ST_BAD_HEX;
          end else begin
            byte_out         = {state_i.high_nibble, hex.value};
            valid            = 1'b1;
            nxt.escape_phase = b64pd_pkg::ESC_NONE;
          end
        end
      endcase
    end

    if (last_char && nxt.err_status == b64pd_pkg::ST_OK &&
        nxt.escape_phase != b64pd_pkg::ESC_NONE) begin
      nxt.err_status = b64pd_pkg::ST_UNFINISHED;
    end

    result_o.out_byte    = byte_out;
    result_o.byte_valid  = valid;
    result_o.end_of_text = last_char;
    result_o.status      = nxt.err_status;

    state_o = last_char ? b64pd_pkg::STATE_RESET : nxt;
  end

endmodule

/* src/base64_percent_decoder_unit.sv */
// An accepted input word's result word is registered and shown on the output in the next cycle.
// Throughput: one word per cycle; a new word is taken whenever the output
// register is empty or its word is taken in the same cycle.
// Reset: synchronous active-low rst_n clears the decoder state and empties the
// output register. Depends on b64pd_pkg and b64pd_step.

module base64_percent_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,   // last_char
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [2:0] out_tuser,  // [0] byte_valid, [2:1] status
  output logic       out_tlast   // end_of_text
);

  b64pd_pkg::dec_state_t  state_r;
  b64pd_pkg::dec_state_t  state_nxt;
  b64pd_pkg::dec_result_t step_res;
  b64pd_pkg::dec_result_t res_r;
  logic                   out_valid_r;
  logic                   accept;

  b64pd_step u_step (
    .state_i   (state_r),
    .char_code (in_tdata),
    .last_char (in_tlast),
    .state_o   (state_nxt),
    .result_o  (step_res)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= b64pd_pkg::STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r <= state_nxt;
      end
      if (in_tready) begin
        out_valid_r <= in_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r.out_byte;
  assign out_tuser  = {res_r.status, res_r.byte_valid};
  assign out_tlast  = res_r.end_of_text;

endmodule

/* src/b64pd_checker.sv */
// Port-level checks for base64_percent_decoder_unit and the bind that attaches
// them. Depends on b64pd_pkg and the top-level port list.

module b64pd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser,
  input logic       out_tlast
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word present right after reset");

  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted word did not reach the output");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 8'd0)
    else $error("byte field nonzero without a decoded byte");

  a_err_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:1] == b64pd_pkg::ST_BAD_CHAR ||
                   out_tuser[2:1] == b64pd_pkg::ST_BAD_HEX) |-> !out_tuser[0])
    else $error("decoded byte reported with an error status");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output word changed");

endmodule

bind base64_percent_decoder_unit b64pd_checker u_b64pd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
